/* rtl/pkrs_pkg.sv */
// Package with shared constants and types for the permuted key record sorter.
package pkrs_pkg;
	localparam int MaxRecords  = 64;
	localparam int RecordBytes = 32;
	localparam int RecW  = $clog2(MaxRecords);
	localparam int PosW  = $clog2(RecordBytes);
	localparam int AddrW = RecW + PosW;
	localparam int LenW  = 6;
	localparam int CntW  = 7;

	typedef enum logic [1:0] {
		REQ_LOAD_PERM = 2'd0,
		REQ_LOAD_BYTE = 2'd1,
		REQ_SORT      = 2'd2,
		REQ_READ_RANK = 2'd3
	} req_t;

	localparam logic [1:0] CFG_LENGTH = 2'd0;
	localparam logic [1:0] CFG_COUNT  = 2'd1;
	localparam logic [1:0] CFG_MODE   = 2'd2;

	localparam logic KIND_SORT = 1'b0;
	localparam logic KIND_RANK = 1'b1;

	// Compare request from sequencer to the compare unit.
	typedef struct packed {
		logic            start;
		logic [RecW-1:0] rec_a;
		logic [RecW-1:0] rec_b;
	} cmp_req_t;

	typedef struct packed {
		logic done;
		logic greater;
	} cmp_rsp_t;
endpackage

/* rtl/pkrs_compare.sv */
// Byte-serial record compare unit that owns the record store and the permutation.
module pkrs_compare (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       byte_we,
	input  logic [pkrs_pkg::RecW-1:0]  byte_rec,
	input  logic [pkrs_pkg::PosW-1:0]  byte_pos,
	input  logic [7:0]                 byte_data,
	input  logic                       perm_we,
	input  logic [pkrs_pkg::PosW-1:0]  perm_pos,
	input  logic [7:0]                 perm_data,
	input  logic [pkrs_pkg::LenW-1:0]  len,
	input  logic                       mode,
	input  pkrs_pkg::cmp_req_t         req,
	output pkrs_pkg::cmp_rsp_t         rsp,
	output logic                       perm_bad
);
	localparam int P = pkrs_pkg::PosW;
	localparam int R = pkrs_pkg::RecW;

	logic [7:0] store_a [pkrs_pkg::MaxRecords*pkrs_pkg::RecordBytes];
	logic [7:0] store_b [pkrs_pkg::MaxRecords*pkrs_pkg::RecordBytes];
	logic [7:0] perm_q  [pkrs_pkg::RecordBytes];
	logic [pkrs_pkg::RecordBytes-1:0] bad_vec;

	typedef enum logic [1:0] {C_IDLE, C_RUN} cst_t;
	cst_t st_q;
	logic [pkrs_pkg::LenW-1:0] k_q;
	logic [R-1:0] a_q, b_q;
	logic rd_s1, last_s1, fin_q, gt_q;
	logic [7:0] xa_s1, xb_s1;
	logic [P-1:0] off;

	// Two copies of the store give two read ports with one write port each.
	always_ff @(posedge clk) begin
		if (byte_we) begin
			store_a[{byte_rec, byte_pos}] <= byte_data;
			store_b[{byte_rec, byte_pos}] <= byte_data;
		end
		if (perm_we) perm_q[perm_pos] <= perm_data;
	end

	always_comb begin
		logic [7:0] pv;
		pv = perm_q[k_q[P-1:0]];
		if (!mode) off = k_q[P-1:0];
		else if (pv >= 8'(pkrs_pkg::RecordBytes)) off = '0;
		else off = pv[P-1:0];
	end

	always_ff @(posedge clk) begin
		xa_s1 <= store_a[{a_q, off}];
		xb_s1 <= store_b[{b_q, off}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE; k_q <= '0; a_q <= '0; b_q <= '0;
			rd_s1 <= 1'b0; last_s1 <= 1'b0; fin_q <= 1'b0; gt_q <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			unique case (st_q)
				C_IDLE: begin
					rd_s1 <= 1'b0;
					if (req.start) begin
						a_q <= req.rec_a; b_q <= req.rec_b; k_q <= '0;
						if (len == '0) begin
							fin_q <= 1'b1; gt_q <= 1'b0;
						end else begin
							st_q <= C_RUN;
						end
					end
				end
				C_RUN: begin
					// A read is issued each cycle; the result of the previous one is checked.
					if (rd_s1 && xa_s1 != xb_s1) begin
						fin_q <= 1'b1; gt_q <= xa_s1 > xb_s1;
						st_q <= C_IDLE; rd_s1 <= 1'b0;
					end else if (rd_s1 && last_s1) begin
						fin_q <= 1'b1; gt_q <= 1'b0;
						st_q <= C_IDLE; rd_s1 <= 1'b0;
					end else if (!last_s1 || !rd_s1) begin
						rd_s1 <= 1'b1;
						last_s1 <= (k_q + 1'b1) == len;
						k_q <= k_q + 1'b1;
						if ((k_q + 1'b1) == len) k_q <= k_q;
					end
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	// Holding k at the last index while the final byte returns needs one extra guard.
	assign rsp.done = fin_q;
	assign rsp.greater = gt_q;

	always_comb begin
		for (int i = 0; i < pkrs_pkg::RecordBytes; i++)
			bad_vec[i] = (i < int'(len)) && (perm_q[i] >= {2'b00, len});
	end
	assign perm_bad = |bad_vec;

	a_fin_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |=> !fin_q || $past(req.start))
		else $error("compare done held");
	a_idle_run: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == C_RUN) |-> !fin_q || $past(st_q == C_RUN) || $past(req.start))
		else $error("compare finished without start");
	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == C_RUN) |-> k_q < len)
		else $error("byte index past length");
endmodule

/* rtl/permuted_key_record_sorter.sv */
// Top level of the permuted key record sorter: request decode, insertion sort sequencer.
//
// Channel  Direction  Handshake        Payload
// in       input      in_valid/stall   req_type record_number byte_position data_value
// out      output     out_valid/stall  result_kind sorted_record status
// cfg      input      cfg_valid/ready  cfg_index cfg_data
//
// Loads write when accepted; a rank read passes a registered table read and S_READ to the output.
// A sort runs insertion sort over the rank table memory, each comparison in the byte-serial compare unit.
// Reset is asynchronous; the rank table leaves reset holding identity through valid bits.
// A stalled result holds the block; no item is accepted until the register drains.
module permuted_key_record_sorter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] req_type,
	input  logic [5:0] record_number,
	input  logic [4:0] byte_position,
	input  logic [7:0] data_value,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       result_kind,
	output logic [5:0] sorted_record,
	output logic       status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int R = pkrs_pkg::RecW;
	localparam int N = pkrs_pkg::MaxRecords;

	logic [pkrs_pkg::LenW-1:0] len_cfg_q;
	logic [pkrs_pkg::CntW-1:0] cnt_cfg_q;
	logic mode_q;
	logic [pkrs_pkg::LenW-1:0] len_eff;
	logic [pkrs_pkg::CntW-1:0] cnt_eff;

	logic [R-1:0] rank_mem [N];
	logic [N-1:0] rank_vld_q;
	logic         rk_we;
	logic [R-1:0] rk_waddr, rk_wdata, rk_raddr, rk_rd_s1;
	logic [R-1:0] rk_raddr_s1;
	logic         rk_vld_s1;
	logic [R-1:0] rk_val;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_SORT_I, S_RD_PREV, S_CMP, S_WAIT, S_DONE
	} st_t;
	st_t st_q;
	logic [pkrs_pkg::CntW-1:0] i_q, j_q;
	logic [R-1:0] cur_q, prev_q;
	logic rdv_q;
	pkrs_pkg::cmp_req_t creq;
	pkrs_pkg::cmp_rsp_t crsp;
	logic perm_bad;
	logic acc;

	assign len_eff = (len_cfg_q > 6'(pkrs_pkg::RecordBytes)) ?
		6'(pkrs_pkg::RecordBytes) : len_cfg_q;
	assign cnt_eff = (cnt_cfg_q > 7'(N)) ? 7'(N) : cnt_cfg_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_cfg_q <= 6'd32; cnt_cfg_q <= 7'd64; mode_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pkrs_pkg::CFG_LENGTH: len_cfg_q <= cfg_data[5:0];
				pkrs_pkg::CFG_COUNT:  cnt_cfg_q <= cfg_data[6:0];
				pkrs_pkg::CFG_MODE:   mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign in_stall = (st_q != S_IDLE) || out_valid;
	assign acc = in_valid && !in_stall;

	pkrs_compare u_cmp (
		.clk, .arst_n,
		.byte_we  (acc && req_type == pkrs_pkg::REQ_LOAD_BYTE),
		.byte_rec (record_number[R-1:0]),
		.byte_pos (byte_position),
		.byte_data(data_value),
		.perm_we  (acc && req_type == pkrs_pkg::REQ_LOAD_PERM),
		.perm_pos (byte_position),
		.perm_data(data_value),
		.len      (len_eff),
		.mode     (mode_q),
		.req      (creq),
		.rsp      (crsp),
		.perm_bad (perm_bad)
	);

	// Rank table; an entry unwritten since reset or a started sort reads as its own index.
	always_ff @(posedge clk) begin
		if (rk_we) rank_mem[rk_waddr] <= rk_wdata;
		rk_rd_s1 <= rank_mem[rk_raddr];
		rk_raddr_s1 <= rk_raddr;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_vld_q <= '0; rk_vld_s1 <= 1'b0;
		end else begin
			rk_vld_s1 <= rank_vld_q[rk_raddr];
			if (st_q == S_IDLE && acc && req_type == pkrs_pkg::REQ_SORT &&
				!(mode_q && perm_bad)) rank_vld_q <= '0;
			else if (rk_we) rank_vld_q[rk_waddr] <= 1'b1;
		end
	end
	assign rk_val = rk_vld_s1 ? rk_rd_s1 : rk_raddr_s1;

	always_comb begin
		rk_raddr = '0;
		unique case (st_q)
			S_IDLE:    rk_raddr = record_number[R-1:0];
			S_SORT_I:  rk_raddr = i_q[R-1:0];
			S_RD_PREV: rk_raddr = R'(j_q - 1'b1);
			default:   rk_raddr = R'(j_q - 1'b1);
		endcase
	end

	always_comb begin
		rk_we = 1'b0; rk_waddr = j_q[R-1:0]; rk_wdata = cur_q;
		creq = '0;
		creq.rec_a = rk_val; creq.rec_b = cur_q;
		if (st_q == S_CMP && rdv_q) creq.start = 1'b1;
		if (st_q == S_WAIT && crsp.done) begin
			rk_we = 1'b1;
			rk_wdata = crsp.greater ? prev_q : cur_q;
		end else if (st_q == S_RD_PREV && j_q == '0) begin
			rk_we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; out_valid <= 1'b0; i_q <= '0; j_q <= '0; rdv_q <= 1'b0;
			cur_q <= '0; prev_q <= '0;
			result_kind <= 1'b0; sorted_record <= '0; status <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			rdv_q <= 1'b0;
			unique case (st_q)
				S_IDLE: if (acc) begin
					if (req_type == pkrs_pkg::REQ_READ_RANK) st_q <= S_READ;
					else if (req_type == pkrs_pkg::REQ_SORT) begin
						i_q <= 7'd1;
						if (mode_q && perm_bad) begin
							out_valid <= 1'b1; result_kind <= pkrs_pkg::KIND_SORT;
							sorted_record <= '0; status <= 1'b1;
						end else st_q <= S_SORT_I;
					end
				end
				S_READ: begin
					out_valid <= 1'b1; result_kind <= pkrs_pkg::KIND_RANK;
					sorted_record <= rk_val; status <= 1'b0;
					st_q <= S_IDLE;
				end
				S_SORT_I: begin
					if (i_q >= cnt_eff) st_q <= S_DONE;
					else begin
						j_q <= i_q; st_q <= S_RD_PREV;
					end
				end
				S_RD_PREV: begin
					// First pass here after S_SORT_I: rk_val is rank[i].
					if (!rdv_q && j_q == i_q) cur_q <= rk_val;
					if (j_q == '0) begin
						i_q <= i_q + 1'b1; st_q <= S_SORT_I;
					end else begin
						st_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (!rdv_q) rdv_q <= 1'b1;
					else begin
						prev_q <= rk_val; st_q <= S_WAIT;
					end
				end
				S_WAIT: if (crsp.done) begin
					if (crsp.greater) begin
						j_q <= j_q - 1'b1; st_q <= S_RD_PREV;
					end else begin
						i_q <= i_q + 1'b1; st_q <= S_SORT_I;
					end
				end
				S_DONE: begin
					out_valid <= 1'b1; result_kind <= pkrs_pkg::KIND_SORT;
					sorted_record <= '0; status <= 1'b0; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != S_IDLE) |-> in_stall)
		else $error("input accepted while busy");
	a_rank_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && result_kind == pkrs_pkg::KIND_RANK) |-> !status)
		else $error("rank read with error status");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !rk_we)
		else $error("rank write outside sort");
endmodule

/* verif/tb_permuted_key_record_sorter.sv */
// Self-checking testbench for the permuted key record sorter with its own sort predictor.
`timescale 1ns / 1ps

module tb_permuted_key_record_sorter;
	import pkrs_pkg::*;

	typedef struct {
		req_t       kind;
		logic [5:0] rec;
		logic [4:0] pos;
		logic [7:0] val;
	} sorter_req_t;

	typedef struct {
		logic       kind;
		logic [5:0] rec;
		logic       stat;
	} sorter_result_t;

	localparam int IdleLimit = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [1:0] req_type = '0;
	logic [5:0] record_number = '0;
	logic [4:0] byte_position = '0;
	logic [7:0] data_value = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       result_kind;
	logic [5:0] sorted_record;
	logic       status;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	permuted_key_record_sorter i_dut (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .record_number, .byte_position,
		.data_value, .out_valid, .out_stall, .result_kind, .sorted_record, .status,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sorter_req_t    pending_reqs[$];
	sorter_result_t expected_results[$];
	int             send_idle_pct = 0;
	int             recv_idle_pct = 0;
	int             hold_seq = 0;
	int             error_count = 0;

	// Predictor state, advanced as transactions are accepted.
	logic [7:0] pred_store[MaxRecords][RecordBytes];
	logic [7:0] pred_perm[RecordBytes];
	logic [5:0] pred_rank[MaxRecords];
	int         pred_length = 32;
	int         pred_count = 64;
	logic       pred_mode = 1'b1;

	// Generation-side view of what has been written, so no sort touches unwritten bytes.
	bit         gen_written[MaxRecords][RecordBytes];
	bit         gen_perm_written[RecordBytes];
	int         gen_length = 32;
	int         gen_count = 64;
	logic       gen_mode = 1'b1;

	function automatic bit key_is_greater(int a, int b, int len);
		int off;
		for (int k = 0; k < len; k++) begin
			off = pred_mode ? int'(pred_perm[k]) : k;
			if (off >= RecordBytes) off = 0;
			if (pred_store[a][off] != pred_store[b][off])
				return pred_store[a][off] > pred_store[b][off];
		end
		return 1'b0;
	endfunction

	function automatic logic predict_sort();
		int len;
		int cnt;
		int j;
		logic [5:0] cur;
		len = pred_length > RecordBytes ? RecordBytes : pred_length;
		cnt = pred_count > MaxRecords ? MaxRecords : pred_count;
		if (pred_mode)
			for (int i = 0; i < len; i++)
				if (pred_perm[i] >= len) return 1'b1;
		for (int i = 0; i < MaxRecords; i++) pred_rank[i] = i[5:0];
		for (int i = 1; i < cnt; i++) begin
			cur = pred_rank[i];
			j = i;
			while (j > 0 && key_is_greater(pred_rank[j-1], cur, len)) begin
				pred_rank[j] = pred_rank[j-1];
				j--;
			end
			pred_rank[j] = cur;
		end
		return 1'b0;
	endfunction

	function automatic void predict_request(sorter_req_t r);
		sorter_result_t e;
		case (r.kind)
			REQ_LOAD_PERM: pred_perm[r.pos] = r.val;
			REQ_LOAD_BYTE: pred_store[r.rec][r.pos] = r.val;
			REQ_SORT: begin
				e.kind = KIND_SORT;
				e.rec  = '0;
				e.stat = predict_sort();
				expected_results.push_back(e);
			end
			default: begin
				e.kind = KIND_RANK;
				e.rec  = pred_rank[r.rec];
				e.stat = 1'b0;
				expected_results.push_back(e);
			end
		endcase
	endfunction

	// Driver: a new transaction is offered only once the previous one was taken.
	always @(posedge clk) begin
		sorter_req_t r;
		if (in_valid && !in_stall) predict_request(pending_reqs.pop_front());
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				r = pending_reqs[0];
				in_valid      <= 1'b1;
				req_type      <= r.kind;
				record_number <= r.rec;
				byte_position <= r.pos;
				data_value    <= r.val;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Monitor with the receiver's stall, including the long hold-off.
	int hold_seen = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		sorter_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with nothing expected: kind %0d", result_kind);
				error_count++;
			end else begin
				e = expected_results.pop_front();
				if (result_kind !== e.kind) begin
					$error("result_kind expected %0d actual %0d", e.kind, result_kind);
					error_count++;
				end
				if (sorted_record !== e.rec) begin
					$error("sorted_record expected %0d actual %0d", e.rec, sorted_record);
					error_count++;
				end
				if (status !== e.stat) begin
					$error("status expected %0d actual %0d", e.stat, status);
					error_count++;
				end
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IdleLimit) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic add_req(req_t kind, int rec, int pos, int val);
		sorter_req_t r;
		r.kind = kind;
		r.rec  = rec[5:0];
		r.pos  = pos[4:0];
		r.val  = val[7:0];
		if (kind == REQ_LOAD_BYTE) gen_written[rec][pos] = 1'b1;
		if (kind == REQ_LOAD_PERM) gen_perm_written[pos] = 1'b1;
		pending_reqs.push_back(r);
	endtask

	task automatic wait_drained();
		do @(posedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(logic [1:0] idx, int value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[7:0];
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_LENGTH: begin pred_length = value & 63; gen_length = pred_length; end
			CFG_COUNT:  begin pred_count = value & 127; gen_count = pred_count; end
			default:    begin pred_mode = value[0]; gen_mode = value[0]; end
		endcase
	endtask

	task automatic set_config(int len, int cnt, int mode);
		write_cfg(CFG_LENGTH, len);
		write_cfg(CFG_COUNT, cnt);
		write_cfg(CFG_MODE, mode);
	endtask

	// Loads a shuffled permutation of 0..len-1 into the used entries.
	task automatic load_permutation();
		int len;
		int order[$];
		len = gen_length > RecordBytes ? RecordBytes : gen_length;
		for (int i = 0; i < len; i++) order.push_back(i);
		order.shuffle();
		for (int i = 0; i < len; i++) add_req(REQ_LOAD_PERM, i, i, order[i]);
	endtask

	// Fills every byte and permutation entry the next sort may read, then sorts.
	task automatic sort_when_ready();
		int len;
		int cnt;
		len = gen_length > RecordBytes ? RecordBytes : gen_length;
		cnt = gen_count > MaxRecords ? MaxRecords : gen_count;
		if (gen_mode)
			for (int i = 0; i < len; i++)
				if (!gen_perm_written[i]) add_req(REQ_LOAD_PERM, 0, i, $urandom_range(0, len - 1));
		for (int r = 0; r < cnt; r++)
			for (int b = 0; b < len; b++)
				if (!gen_written[r][b]) add_req(REQ_LOAD_BYTE, r, b, $urandom_range(0, 3));
		add_req(REQ_SORT, $urandom_range(0, 63), $urandom_range(0, 31), $urandom_range(0, 255));
	endtask

	task automatic random_items(int n);
		int len;
		int cnt;
		int pick;
		len = gen_length > RecordBytes ? RecordBytes : gen_length;
		cnt = gen_count > MaxRecords ? MaxRecords : gen_count;
		if (len == 0) len = 1;
		if (cnt == 0) cnt = 1;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				add_req(REQ_LOAD_BYTE, $urandom_range(0, cnt - 1), $urandom_range(0, len - 1),
					$urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom_range(0, 3));
			else if (pick < 50)
				add_req(REQ_LOAD_PERM, $urandom_range(0, 63), $urandom_range(0, 31),
					$urandom_range(0, 255));
			else if (pick < 53)
				load_permutation();
			else if (pick < 63)
				sort_when_ready();
			else
				add_req(REQ_READ_RANK, $urandom_range(0, 63), $urandom_range(0, 31),
					$urandom_range(0, 255));
		end
	endtask

	task automatic random_phase(int rounds);
		for (int k = 0; k < rounds; k++) begin
			set_config($urandom_range(1, 8), $urandom_range(1, 16), $urandom_range(0, 1));
			load_permutation();
			random_items(75);
			sort_when_ready();
			for (int r = 0; r < 8; r++) add_req(REQ_READ_RANK, $urandom_range(0, 63), 0, 0);
		end
	endtask

	initial begin
		for (int r = 0; r < MaxRecords; r++) pred_rank[r] = r[5:0];
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 14;
		recv_idle_pct = 81;

		// Reset rank table must read as identity.
		add_req(REQ_READ_RANK, 0, 0, 0);
		add_req(REQ_READ_RANK, 63, 31, 255);

		// Permuted compare with ties broken by index.
		set_config(3, 4, 1);
		add_req(REQ_LOAD_PERM, 0, 0, 2);
		add_req(REQ_LOAD_PERM, 0, 1, 0);
		add_req(REQ_LOAD_PERM, 0, 2, 1);
		for (int r = 0; r < 4; r++)
			for (int b = 0; b < 3; b++) add_req(REQ_LOAD_BYTE, r, b, (r == 1) ? 255 : (r & 1) * 9);
		sort_when_ready();
		for (int r = 0; r < 5; r++) add_req(REQ_READ_RANK, r, 0, 0);

		// Offset beyond the length makes the sort fail and keeps the ranks.
		add_req(REQ_LOAD_PERM, 0, 1, 255);
		sort_when_ready();
		add_req(REQ_READ_RANK, 0, 0, 0);
		write_cfg(CFG_MODE, 0);
		sort_when_ready();
		add_req(REQ_READ_RANK, 1, 0, 0);

		// Extremes: zero length, zero count, saturated length and count.
		set_config(0, 0, 1);
		sort_when_ready();
		add_req(REQ_READ_RANK, 2, 0, 0);
		set_config(63, 2, 0);
		sort_when_ready();
		add_req(REQ_READ_RANK, 0, 0, 0);
		set_config(1, 127, 1);
		load_permutation();
		sort_when_ready();
		for (int r = 0; r < 4; r++) add_req(REQ_READ_RANK, $urandom_range(0, 63), 0, 0);
		set_config(32, 4, 1);
		load_permutation();
		sort_when_ready();
		add_req(REQ_READ_RANK, 63, 0, 0);

		random_phase(2);

		// Receiver holds off while reads pile up behind the output register.
		wait_drained();
		hold_seq++;
		for (int r = 0; r < 12; r++) add_req(REQ_READ_RANK, r, 0, 0);
		wait_drained();

		send_idle_pct = 81;
		recv_idle_pct = 14;
		random_phase(2);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(2);

		wait_drained();
		repeat (50) @(posedge clk);
		if (error_count == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
